>>> rtl/output_fault_monitor_macros.svh
// Assertion macros for the output fault monitor.
// Included by the RTL modules that carry concurrent checks; needs clk and rst in scope.
`ifndef OUTPUT_FAULT_MONITOR_MACROS_SVH
`define OUTPUT_FAULT_MONITOR_MACROS_SVH
`ifndef SYNTHESIS
// check sampled on clk, suspended while rst is high
`define OFM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check sampled on clk, also active during reset
`define OFM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OFM_ASSERT(lbl, prop, msg)
`define OFM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> rtl/ofm_pkg.sv
// Shared types and constants for the output fault monitor.
// No dependencies; imported by output_fault_monitor.
package ofm_pkg;

  localparam int unsigned MvW   = 16;
  localparam int unsigned CntW  = 5;
  localparam int unsigned BlankW = 3;

  // ticks of output-on before monitoring starts
  localparam logic [BlankW-1:0] BLANK_TICKS = 3'd4;

  localparam logic [CntW-1:0] COUNT_TRIP = 5'd15;
  localparam logic [CntW-1:0] COUNT_MAX  = 5'd18;

  localparam logic [MvW-1:0] BATT_MIN_FOR_VDD_RST = 16'd3200;
  localparam logic [MvW-1:0] VDD_LOW_RST          = 16'd2900;
  localparam logic [MvW-1:0] VDD_HIGH_RST         = 16'd3100;
  localparam logic [MvW-1:0] INPUT_OVP_RST        = 16'd4350;
  localparam logic [MvW-1:0] LOAD_SPLIT_RST       = 16'd1000;
  localparam logic [MvW-1:0] OPEN_LOAD_RST        = 16'd5900;

  typedef enum logic [2:0] {
    REG_BATT_MIN_FOR_VDD = 3'd0,
    REG_VDD_LOW          = 3'd1,
    REG_VDD_HIGH         = 3'd2,
    REG_INPUT_OVP        = 3'd3,
    REG_LOAD_SPLIT       = 3'd4,
    REG_OPEN_LOAD        = 3'd5
  } reg_index_t;

  typedef enum logic [2:0] {
    CODE_NONE    = 3'd0,
    CODE_MCU     = 3'd1,
    CODE_OVP     = 3'd2,
    CODE_THERMAL = 3'd3,
    CODE_SHORT   = 3'd4,
    CODE_OPEN    = 3'd5,
    CODE_COMM    = 3'd6,
    CODE_INVALID = 3'd7
  } code_t;

  typedef enum logic [2:0] {
    CONV_NORMAL  = 3'd0,
    CONV_THERMAL = 3'd1,
    CONV_ILIMIT  = 3'd2,
    CONV_SHORT   = 3'd3,
    CONV_UNKNOWN = 3'd4,
    CONV_OTHER   = 3'd5
  } conv_state_t;

  // low two bits of the code, offset from CODE_SHORT
  typedef enum logic [1:0] {
    CAT_SHORT   = 2'd0,
    CAT_OPEN    = 2'd1,
    CAT_COMM    = 2'd2,
    CAT_INVALID = 2'd3
  } category_t;

  localparam int unsigned CodeW = $bits(code_t);
  localparam int unsigned ConvW = $bits(conv_state_t);
  localparam int unsigned IdxW  = $bits(reg_index_t);

endpackage

>>> rtl/output_fault_monitor.sv
// Output fault monitor: converter supervisor with saturating fault counter and latched code.
// Depends on ofm_pkg and output_fault_monitor_macros.svh.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+---------------------------------------------
//  item      | item_valid / item_stall    | kind, output_on, conv_state, four mV readings
//  result    | result_valid / result_stall| fault_code, fault_fatal, fault_entered,
//            |                            | in_fault_mode
//  config    | cfg_write                  | cfg_index, cfg_data
//
// Result path from the item transfer:
// input register, then one pass of compares and counter logic into the result register,
// which also updates the state.
// One item per cycle sustained; item_stall only rises while result_stall holds a full
// result register and the input register is occupied.
// Synchronous reset clears both valid flags and the state; thresholds return to defaults.
`include "output_fault_monitor_macros.svh"

module output_fault_monitor (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [ofm_pkg::IdxW-1:0]  cfg_index,
  input  logic [ofm_pkg::MvW-1:0]   cfg_data,
  input  logic                      item_valid,
  output logic                      item_stall,
  input  logic                      kind,
  input  logic                      output_on,
  input  logic [ofm_pkg::ConvW-1:0] conv_state,
  input  logic [ofm_pkg::MvW-1:0]   raw_batt_mv,
  input  logic [ofm_pkg::MvW-1:0]   batt_mv,
  input  logic [ofm_pkg::MvW-1:0]   mcu_vdd_mv,
  input  logic [ofm_pkg::MvW-1:0]   out_mv,
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic [ofm_pkg::CodeW-1:0] fault_code,
  output logic                      fault_fatal,
  output logic                      fault_entered,
  output logic                      in_fault_mode
);
  import ofm_pkg::*;

  // thresholds
  logic [MvW-1:0] batt_min_for_vdd_mv;
  logic [MvW-1:0] vdd_low_mv;
  logic [MvW-1:0] vdd_high_mv;
  logic [MvW-1:0] input_ovp_mv;
  logic [MvW-1:0] load_split_mv;
  logic [MvW-1:0] open_load_mv;

  // input register
  logic              s1_valid;
  logic              s1_kind;
  logic              s1_on;
  conv_state_t       s1_state;
  logic [MvW-1:0]    s1_raw;
  logic [MvW-1:0]    s1_batt;
  logic [MvW-1:0]    s1_vdd;
  logic [MvW-1:0]    s1_out;

  // supervisor state
  logic [BlankW-1:0] blank_count;
  logic [CntW-1:0]   fault_count;
  category_t         fault_category;
  code_t             latched_code;
  logic              fault_mode;

  logic [BlankW-1:0] blank_count_next;
  logic [CntW-1:0]   fault_count_next;
  category_t         fault_category_next;
  code_t             latched_code_next;
  logic              fault_mode_next;
  logic              entered_next;

  logic advance;
  logic load;
  logic mcu_bad;
  logic ovp_bad;
  logic thermal;
  logic trip;

  function automatic logic [CntW-1:0] add_weight(input logic [CntW-1:0] cnt,
                                                 input logic [CntW-1:0] weight);
    return (cnt < COUNT_TRIP) ? CntW'(cnt + weight) : COUNT_TRIP;
  endfunction

  assign advance    = !result_valid || !result_stall;
  assign load       = s1_valid && advance;
  assign item_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      batt_min_for_vdd_mv <= BATT_MIN_FOR_VDD_RST;
      vdd_low_mv          <= VDD_LOW_RST;
      vdd_high_mv         <= VDD_HIGH_RST;
      input_ovp_mv        <= INPUT_OVP_RST;
      load_split_mv       <= LOAD_SPLIT_RST;
      open_load_mv        <= OPEN_LOAD_RST;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_BATT_MIN_FOR_VDD: batt_min_for_vdd_mv <= cfg_data;
        REG_VDD_LOW:          vdd_low_mv          <= cfg_data;
        REG_VDD_HIGH:         vdd_high_mv         <= cfg_data;
        REG_INPUT_OVP:        input_ovp_mv        <= cfg_data;
        REG_LOAD_SPLIT:       load_split_mv       <= cfg_data;
        REG_OPEN_LOAD:        open_load_mv        <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
    if (!item_stall && item_valid) begin
      s1_kind  <= kind;
      s1_on    <= output_on;
      s1_state <= conv_state_t'(conv_state);
      s1_raw   <= raw_batt_mv;
      s1_batt  <= batt_mv;
      s1_vdd   <= mcu_vdd_mv;
      s1_out   <= out_mv;
    end
  end

  always_comb begin
    blank_count_next    = blank_count;
    fault_count_next    = fault_count;
    fault_category_next = fault_category;
    latched_code_next   = latched_code;
    fault_mode_next     = fault_mode;
    entered_next        = 1'b0;
    mcu_bad             = ((s1_raw > batt_min_for_vdd_mv) && (s1_vdd < vdd_low_mv)) ||
                          (s1_vdd > vdd_high_mv);
    ovp_bad             = s1_batt > input_ovp_mv;
    thermal             = 1'b0;
    trip                = 1'b0;

    if (s1_kind) begin
      latched_code_next = CODE_NONE;
      fault_mode_next   = 1'b0;
    end else if (!s1_on) begin
      blank_count_next = '0;
    end else if (blank_count < BLANK_TICKS) begin
      blank_count_next = BlankW'(blank_count + 1'b1);
    end else begin
      // ovp and thermal leave counter and category as they were
      if (!ovp_bad) begin
        unique case (s1_state)
          CONV_THERMAL: thermal = 1'b1;
          CONV_ILIMIT, CONV_SHORT: begin
            fault_count_next    = add_weight(fault_count, CntW'(4));
            fault_category_next = (s1_out > load_split_mv) ? CAT_INVALID : CAT_SHORT;
          end
          CONV_UNKNOWN: begin
            fault_count_next    = add_weight(fault_count, CntW'(1));
            fault_category_next = CAT_COMM;
          end
          CONV_NORMAL: begin
            fault_count_next    = (s1_out < open_load_mv) ? '0 :
                                  add_weight(fault_count, CntW'(2));
            fault_category_next = CAT_OPEN;
          end
          default: fault_count_next = '0;
        endcase
      end
      trip = fault_count_next >= COUNT_TRIP;

      // trip has priority over ovp, then thermal, then mcu
      priority if (trip) begin
        latched_code_next = code_t'(CODE_SHORT | {1'b0, fault_category_next});
      end else if (ovp_bad) begin
        latched_code_next = CODE_OVP;
      end else if (thermal) begin
        latched_code_next = CODE_THERMAL;
      end else if (mcu_bad) begin
        latched_code_next = CODE_MCU;
      end else begin
        latched_code_next = latched_code;
      end

      if ((trip || ovp_bad || thermal || mcu_bad) && !fault_mode) begin
        fault_mode_next = 1'b1;
        entered_next    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blank_count    <= '0;
      fault_count    <= '0;
      fault_category <= CAT_SHORT;
      latched_code   <= CODE_NONE;
      fault_mode     <= 1'b0;
    end else if (load) begin
      blank_count    <= blank_count_next;
      fault_count    <= fault_count_next;
      fault_category <= fault_category_next;
      latched_code   <= latched_code_next;
      fault_mode     <= fault_mode_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= s1_valid;
    end
    if (load) begin
      fault_code    <= latched_code_next;
      fault_fatal   <= !(latched_code_next == CODE_NONE || latched_code_next == CODE_SHORT ||
                         latched_code_next == CODE_OPEN || latched_code_next == CODE_OVP);
      fault_entered <= entered_next;
      in_fault_mode <= fault_mode_next;
    end
  end

  `OFM_ASSERT(a_count_bound, fault_count <= COUNT_MAX, "fault counter out of range")
  `OFM_ASSERT(a_blank_bound, blank_count <= BLANK_TICKS, "blanking counter past limit")
  `OFM_ASSERT(a_stall_full, item_stall |-> (s1_valid && result_valid), "stall with room")
  `OFM_ASSERT(a_clear_result,
    (load && s1_kind) |=> (fault_code == CODE_NONE && !in_fault_mode && !fault_entered),
    "clear did not empty code")
  `OFM_ASSERT(a_entry_mode, (load && entered_next) |-> (!fault_mode && fault_mode_next), "entry flag without mode change")
  `OFM_ASSERT_ALWAYS(a_reset_idle, rst |=> (!result_valid && !s1_valid), "valid after reset")

endmodule

>>> dv/output_fault_monitor_tb.sv
// Self-checking testbench for output_fault_monitor: directed supervision paths, threshold
// extremes and long random tick streams, checked against an in-bench fault predictor.
// Depends on ofm_pkg and the output_fault_monitor RTL.
module output_fault_monitor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ofm_pkg::*;

  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  localparam logic [CntW-1:0] WEIGHT_LIMIT   = 5'd4;
  localparam logic [CntW-1:0] WEIGHT_UNKNOWN = 5'd1;
  localparam logic [CntW-1:0] WEIGHT_OPEN    = 5'd2;

  localparam int NUM_REGS = int'(REG_OPEN_LOAD) + 1;

  localparam logic [MvW-1:0] DEFAULT_THR [0:NUM_REGS-1] = '{
    BATT_MIN_FOR_VDD_RST, VDD_LOW_RST, VDD_HIGH_RST,
    INPUT_OVP_RST, LOAD_SPLIT_RST, OPEN_LOAD_RST
  };

  localparam logic [MvW-1:0] NOM_BATT_MV = 16'd3700;
  localparam logic [MvW-1:0] NOM_VDD_MV  = 16'd3000;
  localparam logic [MvW-1:0] NOM_OUT_MV  = 16'd500;
  localparam logic [MvW-1:0] ALL_ONES_MV = 16'hFFFF;

  typedef struct {
    logic             kind;
    logic             output_on;
    logic [ConvW-1:0] conv_state;
    logic [MvW-1:0]   raw_batt_mv;
    logic [MvW-1:0]   batt_mv;
    logic [MvW-1:0]   mcu_vdd_mv;
    logic [MvW-1:0]   out_mv;
  } monitor_item_t;

  typedef struct {
    code_t code;
    logic  fatal;
    logic  entered;
    logic  mode;
  } fault_status_t;

  logic             clk;
  logic             rst = 1'b1;
  logic             cfg_write = 1'b0;
  logic [IdxW-1:0]  cfg_index = '0;
  logic [MvW-1:0]   cfg_data = '0;
  logic             item_valid = 1'b0;
  logic             item_stall;
  logic             kind = 1'b0;
  logic             output_on = 1'b0;
  logic [ConvW-1:0] conv_state = '0;
  logic [MvW-1:0]   raw_batt_mv = '0;
  logic [MvW-1:0]   batt_mv = '0;
  logic [MvW-1:0]   mcu_vdd_mv = '0;
  logic [MvW-1:0]   out_mv = '0;
  logic             result_valid;
  logic             result_stall = 1'b0;
  logic [CodeW-1:0] fault_code;
  logic             fault_fatal;
  logic             fault_entered;
  logic             in_fault_mode;

  output_fault_monitor dut (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .item_valid, .item_stall, .kind, .output_on, .conv_state,
    .raw_batt_mv, .batt_mv, .mcu_vdd_mv, .out_mv,
    .result_valid, .result_stall, .fault_code, .fault_fatal,
    .fault_entered, .in_fault_mode
  );

  // predictor state
  logic [MvW-1:0]    thr [0:NUM_REGS-1];
  logic [BlankW-1:0] blank_cnt;
  logic [CntW-1:0]   fault_cnt;
  category_t         category;
  code_t             held_code;
  logic              fault_on;
  logic              entered_flag;

  fault_status_t status_q [$];
  int errors = 0;
  bit send_gaps = 1'b1;
  bit stall_en = 1'b1;
  logic [ConvW-1:0] last_conv = CONV_NORMAL;
  logic [MvW-1:0]   last_out = NOM_OUT_MV;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [MvW-1:0] near_level(input logic [MvW-1:0] level);
    case ($urandom_range(0, 3))
      0: return MvW'($urandom);
      1: return level - 1'b1;
      2: return level;
      default: return level + 1'b1;
    endcase
  endfunction

  function automatic logic [CntW-1:0] add_weight(input logic [CntW-1:0] c,
                                                 input logic [CntW-1:0] w);
    return (c < COUNT_TRIP) ? c + w : COUNT_TRIP;
  endfunction

  function automatic void latch_fault(input code_t c);
    held_code = c;
    if (!fault_on) begin
      fault_on = 1'b1;
      entered_flag = 1'b1;
    end
  endfunction

  function automatic fault_status_t predict_fault_status(input monitor_item_t t);
    fault_status_t r;
    logic [CntW-1:0] cnt;
    entered_flag = 1'b0;
    if (t.kind == KIND_CLEAR) begin
      held_code = CODE_NONE;
      fault_on = 1'b0;
    end else if (!t.output_on) begin
      blank_cnt = '0;
    end else if (blank_cnt < BLANK_TICKS) begin
      blank_cnt = blank_cnt + 1'b1;
    end else begin
      cnt = fault_cnt;
      if (t.raw_batt_mv > thr[REG_BATT_MIN_FOR_VDD] && t.mcu_vdd_mv < thr[REG_VDD_LOW])
        latch_fault(CODE_MCU);
      if (t.mcu_vdd_mv > thr[REG_VDD_HIGH])
        latch_fault(CODE_MCU);
      // ovp and thermal leave both counter and category alone
      if (t.batt_mv > thr[REG_INPUT_OVP]) begin
        latch_fault(CODE_OVP);
      end else if (t.conv_state == CONV_THERMAL) begin
        latch_fault(CODE_THERMAL);
      end else if (t.conv_state == CONV_ILIMIT || t.conv_state == CONV_SHORT) begin
        cnt = add_weight(cnt, WEIGHT_LIMIT);
        category = (t.out_mv > thr[REG_LOAD_SPLIT]) ? CAT_INVALID : CAT_SHORT;
      end else if (t.conv_state == CONV_UNKNOWN) begin
        cnt = add_weight(cnt, WEIGHT_UNKNOWN);
        category = CAT_COMM;
      end else if (t.conv_state == CONV_NORMAL) begin
        cnt = (t.out_mv < thr[REG_OPEN_LOAD]) ? '0 : add_weight(cnt, WEIGHT_OPEN);
        category = CAT_OPEN;
      end else begin
        cnt = '0;
      end
      fault_cnt = cnt;
      if (fault_cnt >= COUNT_TRIP)
        latch_fault(code_t'(CODE_SHORT + category));
    end
    r.code = held_code;
    r.fatal = !(held_code inside {CODE_NONE, CODE_SHORT, CODE_OPEN, CODE_OVP});
    r.entered = entered_flag;
    r.mode = fault_on;
    return r;
  endfunction

  // four-state compare so an unknown output never passes
  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    fault_status_t want;
    if (!rst && result_valid && !result_stall) begin
      if (status_q.size() == 0) begin
        $error("result transfer with no status pending");
        errors++;
      end else begin
        want = status_q.pop_front();
        check_field("fault_code", 32'(want.code), 32'(fault_code));
        check_field("fault_fatal", 32'(want.fatal), 32'(fault_fatal));
        check_field("fault_entered", 32'(want.entered), 32'(fault_entered));
        check_field("in_fault_mode", 32'(want.mode), 32'(in_fault_mode));
      end
    end
  end

  initial begin : result_backpressure
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        result_stall <= 1'b1;
        hold--;
      end else begin
        result_stall <= 1'b0;
        if (stall_en && $urandom_range(0, 7) == 0) hold = gap_len();
      end
    end
  end

  // called just after a rising edge; returns at the transfer edge or after the gap
  task automatic send_item(input monitor_item_t t);
    int gap;
    item_valid  <= 1'b1;
    kind        <= t.kind;
    output_on   <= t.output_on;
    conv_state  <= t.conv_state;
    raw_batt_mv <= t.raw_batt_mv;
    batt_mv     <= t.batt_mv;
    mcu_vdd_mv  <= t.mcu_vdd_mv;
    out_mv      <= t.out_mv;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    status_q.push_back(predict_fault_status(t));
    gap = (send_gaps && $urandom_range(0, 3) == 0) ? gap_len() : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic tick(input logic on, input logic [ConvW-1:0] st,
                      input logic [MvW-1:0] raw, input logic [MvW-1:0] batt,
                      input logic [MvW-1:0] vdd, input logic [MvW-1:0] outv);
    monitor_item_t t;
    t = '{kind: KIND_TICK, output_on: on, conv_state: st, raw_batt_mv: raw,
          batt_mv: batt, mcu_vdd_mv: vdd, out_mv: outv};
    send_item(t);
  endtask

  task automatic clear_fault();
    monitor_item_t t;
    t = '{kind: KIND_CLEAR, output_on: 1'b1, conv_state: '1, raw_batt_mv: ALL_ONES_MV,
          batt_mv: ALL_ONES_MV, mcu_vdd_mv: ALL_ONES_MV, out_mv: ALL_ONES_MV};
    send_item(t);
  endtask

  task automatic wait_idle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_thresholds(input logic [MvW-1:0] v [0:NUM_REGS-1]);
    wait_idle();
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= reg_index_t'(i);
      cfg_data  <= v[i];
      thr[i] = v[i];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  function automatic logic [ConvW-1:0] pick_conv();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return CONV_NORMAL;
    if (r < 30) return CONV_THERMAL;
    if (r < 45) return CONV_ILIMIT;
    if (r < 65) return CONV_SHORT;
    if (r < 85) return CONV_UNKNOWN;
    if (r < 93) return CONV_OTHER;
    return ConvW'($urandom_range(int'(CONV_OTHER) + 1, (1 << ConvW) - 1));
  endfunction

  // mostly plausible ticks with sticky status and output level so counters can trip
  function automatic monitor_item_t rand_item();
    monitor_item_t t;
    logic [MvW-1:0] lo, hi;
    if ($urandom_range(0, 9) == 0) begin
      t.kind = 1'($urandom);
      t.output_on = 1'($urandom);
      t.conv_state = ConvW'($urandom);
      t.raw_batt_mv = MvW'($urandom);
      t.batt_mv = MvW'($urandom);
      t.mcu_vdd_mv = MvW'($urandom);
      t.out_mv = MvW'($urandom);
      return t;
    end
    t.kind = ($urandom_range(0, 39) == 0) ? KIND_CLEAR : KIND_TICK;
    t.output_on = ($urandom_range(0, 49) != 0);
    if ($urandom_range(0, 9) < 3) last_conv = pick_conv();
    if ($urandom_range(0, 9) < 3) begin
      case ($urandom_range(0, 2))
        0: last_out = near_level(thr[REG_LOAD_SPLIT]);
        1: last_out = near_level(thr[REG_OPEN_LOAD]);
        default: last_out = MvW'($urandom);
      endcase
    end
    t.conv_state = last_conv;
    t.out_mv = last_out;
    t.raw_batt_mv = near_level(thr[REG_BATT_MIN_FOR_VDD]);
    t.batt_mv = ($urandom_range(0, 9) < 8) ? MvW'($urandom_range(0, thr[REG_INPUT_OVP]))
                                           : near_level(thr[REG_INPUT_OVP]);
    lo = thr[REG_VDD_LOW];
    hi = thr[REG_VDD_HIGH];
    if (lo <= hi && $urandom_range(0, 99) < 85)
      t.mcu_vdd_mv = MvW'($urandom_range(lo, hi));
    else
      t.mcu_vdd_mv = near_level($urandom_range(0, 1) ? lo : hi);
    return t;
  endfunction

  task automatic test_directed_paths();
    clear_fault();
    tick(1'b0, CONV_NORMAL, '0, '0, '0, '0);
    // blanking ticks ignore a short
    repeat (int'(BLANK_TICKS))
      tick(1'b1, CONV_SHORT, NOM_BATT_MV, NOM_BATT_MV, NOM_VDD_MV, NOM_OUT_MV);
    tick(1'b1, CONV_NORMAL, NOM_BATT_MV, NOM_BATT_MV, NOM_VDD_MV, NOM_OUT_MV);
    tick(1'b1, CONV_NORMAL, BATT_MIN_FOR_VDD_RST + 1'b1, NOM_BATT_MV,
         VDD_LOW_RST - 1'b1, NOM_OUT_MV);
    clear_fault();
    // low supply at the battery floor is not a fault; ovp is
    tick(1'b1, CONV_NORMAL, BATT_MIN_FOR_VDD_RST, ALL_ONES_MV, '0, NOM_OUT_MV);
    clear_fault();
    // supply high, then thermal overrides it in the same tick
    tick(1'b1, CONV_THERMAL, NOM_BATT_MV, NOM_BATT_MV, VDD_HIGH_RST + 1'b1, NOM_OUT_MV);
    clear_fault();
    repeat (3) tick(1'b1, CONV_SHORT, NOM_BATT_MV, NOM_BATT_MV, NOM_VDD_MV, LOAD_SPLIT_RST);
    tick(1'b1, CONV_ILIMIT, NOM_BATT_MV, NOM_BATT_MV, NOM_VDD_MV, LOAD_SPLIT_RST);
    // thermal keeps the tripped counter, so the stored category wins
    tick(1'b1, CONV_THERMAL, NOM_BATT_MV, NOM_BATT_MV, NOM_VDD_MV, NOM_OUT_MV);
    tick(1'b1, CONV_ILIMIT, NOM_BATT_MV, NOM_BATT_MV, NOM_VDD_MV, LOAD_SPLIT_RST + 1'b1);
    clear_fault();
    tick(1'b1, CONV_UNKNOWN, NOM_BATT_MV, NOM_BATT_MV, NOM_VDD_MV, NOM_OUT_MV);
    tick(1'b1, CONV_NORMAL, NOM_BATT_MV, NOM_BATT_MV, NOM_VDD_MV, ALL_ONES_MV);
    tick(1'b1, CONV_NORMAL, NOM_BATT_MV, NOM_BATT_MV, NOM_VDD_MV, OPEN_LOAD_RST - 1'b1);
    tick(1'b1, CONV_OTHER, NOM_BATT_MV, NOM_BATT_MV, NOM_VDD_MV, NOM_OUT_MV);
    tick(1'b1, '1, ALL_ONES_MV, NOM_BATT_MV, NOM_VDD_MV, ALL_ONES_MV);
    tick(1'b0, CONV_SHORT, NOM_BATT_MV, NOM_BATT_MV, NOM_VDD_MV, NOM_OUT_MV);
  endtask

  task automatic test_threshold_extremes();
    logic [MvW-1:0] v [0:NUM_REGS-1];
    foreach (v[i]) v[i] = '0;
    apply_thresholds(v);
    repeat (90) send_item(rand_item());
    foreach (v[i]) v[i] = ALL_ONES_MV;
    apply_thresholds(v);
    repeat (90) send_item(rand_item());
  endtask

  task automatic test_random_supervision();
    logic [MvW-1:0] v [0:NUM_REGS-1];
    for (int phase = 0; phase < 6; phase++) begin
      foreach (v[i]) begin
        case ($urandom_range(0, 3))
          0: v[i] = MvW'($urandom);
          1: v[i] = DEFAULT_THR[i];
          2: v[i] = MvW'(DEFAULT_THR[i] + $urandom_range(0, 400) - 200);
          default: v[i] = $urandom_range(0, 1) ? ALL_ONES_MV : '0;
        endcase
      end
      apply_thresholds(v);
      // every third phase runs back to back with no idling on either side
      send_gaps = (phase % 3 != 0);
      stall_en = (phase % 3 != 0);
      repeat (170) send_item(rand_item());
    end
    send_gaps = 1'b1;
    stall_en = 1'b1;
  endtask

  initial begin
    foreach (thr[i]) thr[i] = DEFAULT_THR[i];
    blank_cnt = '0;
    fault_cnt = '0;
    category = CAT_SHORT;
    held_code = CODE_NONE;
    fault_on = 1'b0;
    entered_flag = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_directed_paths();
    test_threshold_extremes();
    test_random_supervision();

    wait_idle();
    if (status_q.size() != 0) begin
      $error("%0d status transfers never arrived", status_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
